// ===== hdl/ekw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch key window package
// Shared types and codes for the epoch key window manager and its parts.
// ----------------------------------------------------------------------------
package ekw_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_REPLACE = 2'd1,
    OP_ITERATE = 2'd2,
    OP_START   = 2'd3
  } op_t;

  localparam logic [2:0] KIND_HIT        = 3'd0;
  localparam logic [2:0] KIND_MISS       = 3'd1;
  localparam logic [2:0] KIND_DERIVE_FUT = 3'd2;
  localparam logic [2:0] KIND_DERIVE_TX  = 3'd3;
  localparam logic [2:0] KIND_ROTATED    = 3'd4;
  localparam logic [2:0] KIND_NOT_FOUND  = 3'd5;

  localparam logic [1:0] SLOT_CURRENT  = 2'd0;
  localparam logic [1:0] SLOT_RETIRING = 2'd1;
  localparam logic [1:0] SLOT_FUTURE   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] epoch;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  slot;
    logic [3:0]  future_index;
    logic [15:0] key_epoch;
    logic        move_replay_window;
    logic        reset_send_counter;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_SEARCH,
    S_NOTFOUND,
    S_REP_SEND,
    S_REP_UPD,
    S_START_UPD,
    S_CALC,
    S_ROT,
    S_START_SEND,
    S_SWEEP,
    S_ITER
  } state_t;

  typedef enum logic [2:0] {
    R_LOOK,
    R_NOTFOUND,
    R_SEND_REP,
    R_ITER,
    R_START_SEND,
    R_ROT,
    R_DERIVE
  } res_t;

  typedef enum logic [1:0] {
    RS_CNT,
    RS_LOOK,
    RS_SHIFT
  } rsel_t;

  typedef struct packed {
    logic  load;
    logic  emit;
    res_t  res;
    logic  last;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  found;
    logic  rep_upd;
    logic  start_upd;
    logic  calc;
    logic  shift_wr;
    rsel_t rsel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic out_free;
    logic hit;
    logic cnt_last;
    logic enc_lt;
    logic top;
    logic num_zero;
  } sts_t;

endpackage

// ===== hdl/ekw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch key window controller
// Sequences lookups, window searches, promotions, send iterates and window refills.
// ----------------------------------------------------------------------------
module ekw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ekw_pkg::op_t  in_op,
  output logic          in_ready,
  input  ekw_pkg::sts_t sts,
  output ekw_pkg::cmd_t cmd
);
  import ekw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.res    = R_LOOK;
    cmd.rsel   = RS_CNT;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
          case (in_op)
            OP_LOOKUP:  state_next = S_LOOK;
            OP_REPLACE: state_next = S_SEARCH;
            OP_ITERATE: state_next = S_ITER;
            OP_START:   state_next = S_START_UPD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        cmd.rsel = RS_LOOK;
        cmd.res  = R_LOOK;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        cmd.rsel = RS_CNT;
        if (sts.hit) begin
          cmd.found  = 1'b1;
          state_next = sts.enc_lt ? S_REP_SEND : S_REP_UPD;
        end else if (sts.cnt_last) begin
          state_next = S_NOTFOUND;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_NOTFOUND: begin
        cmd.res  = R_NOTFOUND;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REP_SEND: begin
        cmd.res = R_SEND_REP;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_REP_UPD;
        end
      end
      S_REP_UPD: begin
        cmd.rep_upd = 1'b1;
        state_next  = S_CALC;
      end
      S_START_UPD: begin
        cmd.start_upd = 1'b1;
        state_next    = S_CALC;
      end
      S_CALC: begin
        cmd.calc    = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next  = (sts.op == OP_REPLACE) ? S_ROT : S_START_SEND;
      end
      S_ROT: begin
        cmd.res  = R_ROT;
        cmd.last = sts.num_zero;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_SWEEP;
        end
      end
      S_START_SEND: begin
        cmd.res  = R_START_SEND;
        cmd.last = sts.num_zero;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.rsel = RS_SHIFT;
        cmd.res  = R_DERIVE;
        cmd.last = sts.cnt_last;
        if (!sts.top) begin
          cmd.shift_wr = 1'b1;
          if (sts.cnt_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.cnt_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      S_ITER: begin
        cmd.res  = R_ITER;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/ekw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch key window datapath
// Epoch registers, the future window store, the walk counter and the output
// register.
// ----------------------------------------------------------------------------
module ekw_dp #(
  parameter int WINDOW_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ekw_pkg::in_item_t in_item,
  input  ekw_pkg::cmd_t     cmd,
  output ekw_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output ekw_pkg::out_item_t out_item
);
  import ekw_pkg::*;

  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam int SW = CW + 1;
  localparam logic [15:0] W16       = 16'(WINDOW_SIZE);
  localparam logic [15:0] TOP_LIMIT = 16'(65534 - WINDOW_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_SIZE - 1);

  logic [1:0]    op_q;
  logic [15:0]   ep_q;
  logic [15:0]   decrypt_epoch;
  logic [15:0]   retiring_epoch;
  logic [15:0]   encrypt_epoch;
  logic [15:0]   send_chain_epoch;
  logic [15:0]   recv_chain_epoch;
  logic [15:0]   future_epochs [WINDOW_SIZE];
  logic [IW-1:0] cnt;
  logic [IW-1:0] found_idx;
  logic [CW-1:0] num;

  logic [16:0]   diff;
  logic [15:0]   look_off;
  logic [IW-1:0] look_idx;
  logic          in_win;
  logic [SW-1:0] sh_sum;
  logic          top;
  logic [IW-1:0] raddr;
  logic [15:0]   rdata;
  logic [15:0]   clean;
  logic [15:0]   nraw;
  logic [CW-1:0] num_next;
  logic [15:0]   send_max;
  logic [15:0]   send_inc;
  logic [15:0]   recv_inc;
  logic          out_free;
  out_item_t     res_item;

  function automatic logic [3:0] fidx(input logic [IW-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[3:0];
  endfunction

  assign diff     = {1'b0, ep_q} - {1'b0, decrypt_epoch};
  assign look_off = diff[15:0] - 16'd1;
  assign look_idx = look_off[IW-1:0];
  assign in_win   = (ep_q > decrypt_epoch) && (diff[15:0] <= W16) && (ep_q <= TOP_LIMIT);

  assign sh_sum = SW'(cnt) + SW'(num);
  assign top    = sh_sum >= SW'(WINDOW_SIZE);

  always_comb begin
    case (cmd.rsel)
      RS_CNT:   raddr = cnt;
      RS_LOOK:  raddr = look_idx;
      RS_SHIFT: raddr = sh_sum[IW-1:0];
      default:  raddr = cnt;
    endcase
  end

  assign rdata = future_epochs[raddr];
  assign clean = ((rdata != 16'd0) && (rdata < decrypt_epoch)) ? 16'd0 : rdata;

  assign nraw     = decrypt_epoch + W16 - recv_chain_epoch;
  assign num_next = (nraw > W16) ? CW'(WINDOW_SIZE) : nraw[CW-1:0];

  assign send_max = (send_chain_epoch < ep_q) ? ep_q : send_chain_epoch;
  assign send_inc = send_chain_epoch + 16'd1;
  assign recv_inc = recv_chain_epoch + 16'd1;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.op       = op_t'(op_q);
    sts.out_free = out_free;
    sts.hit      = (rdata != 16'd0) && (rdata == ep_q);
    sts.cnt_last = cnt == LAST_IDX;
    sts.enc_lt   = encrypt_epoch < ep_q;
    sts.top      = top;
    sts.num_zero = num == '0;
  end

  always_comb begin
    res_item      = '0;
    res_item.last = cmd.last;
    case (cmd.res)
      R_LOOK: begin
        if (ep_q == decrypt_epoch) begin
          res_item.kind      = KIND_HIT;
          res_item.slot      = SLOT_CURRENT;
          res_item.key_epoch = decrypt_epoch;
        end else if ((retiring_epoch != 16'd0) && (retiring_epoch == ep_q)) begin
          res_item.kind      = KIND_HIT;
          res_item.slot      = SLOT_RETIRING;
          res_item.key_epoch = retiring_epoch;
        end else if (in_win) begin
          res_item.kind         = KIND_HIT;
          res_item.slot         = SLOT_FUTURE;
          res_item.future_index = fidx(look_idx);
          res_item.key_epoch    = rdata;
        end else begin
          res_item.kind      = KIND_MISS;
          res_item.key_epoch = ep_q;
        end
      end
      R_NOTFOUND: begin
        res_item.kind      = KIND_NOT_FOUND;
        res_item.key_epoch = ep_q;
      end
      R_SEND_REP: begin
        res_item.kind      = KIND_DERIVE_TX;
        res_item.key_epoch = send_max;
      end
      R_ITER: begin
        res_item.kind               = KIND_DERIVE_TX;
        res_item.key_epoch          = send_inc;
        res_item.reset_send_counter = 1'b1;
      end
      R_START_SEND: begin
        res_item.kind               = KIND_DERIVE_TX;
        res_item.key_epoch          = ep_q;
        res_item.reset_send_counter = 1'b1;
      end
      R_ROT: begin
        res_item.kind               = KIND_ROTATED;
        res_item.key_epoch          = decrypt_epoch;
        res_item.move_replay_window = 1'b1;
      end
      R_DERIVE: begin
        res_item.kind         = KIND_DERIVE_FUT;
        res_item.future_index = fidx(cnt);
        res_item.key_epoch    = recv_inc;
      end
      default: begin
        res_item.kind = KIND_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= in_item.op;
      ep_q <= in_item.epoch;
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + IW'(1);
    end
    if (cmd.found) begin
      found_idx <= cnt;
    end
    if (cmd.calc) begin
      num <= num_next;
    end
    if (cmd.emit) begin
      out_item <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_epoch    <= '0;
      retiring_epoch   <= '0;
      encrypt_epoch    <= '0;
      send_chain_epoch <= '0;
      recv_chain_epoch <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        future_epochs[i] <= '0;
      end
    end else begin
      if (cmd.emit && (cmd.res == R_SEND_REP)) begin
        send_chain_epoch <= send_max;
        encrypt_epoch    <= send_max;
      end
      if (cmd.emit && (cmd.res == R_ITER)) begin
        send_chain_epoch <= send_inc;
        encrypt_epoch    <= send_inc;
      end
      if (cmd.emit && (cmd.res == R_DERIVE)) begin
        recv_chain_epoch <= recv_inc;
        future_epochs[cnt] <= recv_inc;
      end
      if (cmd.shift_wr) begin
        future_epochs[cnt] <= clean;
      end
      if (cmd.rep_upd) begin
        retiring_epoch           <= decrypt_epoch;
        decrypt_epoch            <= ep_q;
        future_epochs[found_idx] <= '0;
      end
      if (cmd.start_upd) begin
        decrypt_epoch    <= ep_q;
        encrypt_epoch    <= ep_q;
        send_chain_epoch <= ep_q;
        recv_chain_epoch <= ep_q;
        retiring_epoch   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/epoch_key_window_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch key window manager
// Epoch bookkeeping of one data-channel key slot with a window of future
// receive epochs; emits derive commands in place of key material.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat type   Handshake
// in        input      in_item_t   in_valid / in_ready
// out       output     out_item_t  out_valid / out_ready
//
// One item is worked on at a time. A replace searches the window one entry a
// cycle and, if it finds the epoch, sweeps it once more to shift and refill
// it, one entry a cycle but where a derive beat waits on a stalled output. A
// start sweeps the window once to refill it. Reset clears every epoch and the
// window at once. A stalled output holds the walk at the next beat; an input
// is taken while the last beat waits.
// ----------------------------------------------------------------------------
module epoch_key_window_manager #(
  parameter int WINDOW_SIZE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ekw_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ekw_pkg::out_item_t out_item
);
  import ekw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ekw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (op_t'(in_item.op)),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ekw_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("A result was loaded over a beat still waiting.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A second item was taken while one is in work.");

  a_shift_below: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> !sts.top)
    else $error("A shift write reached the refill region.");

  a_derive_top: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && (cmd.res == R_DERIVE) |-> sts.top)
    else $error("A derive was issued below the refill region.");

endmodule
